/* src/mccm_pkg.sv */
`timescale 1ns / 1ps

package mccm_pkg;

    // Field and arithmetic widths
    localparam int LEVEL_BITS = 8;
    localparam int SQUARE_BITS = 2 * LEVEL_BITS;
    localparam int SUM_BITS = 32;
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int DIV_STEP_BITS = $clog2(SUM_BITS);
    localparam int ROOT_STEP_BITS = $clog2(ROOT_BITS);
    localparam int GAP_BITS = 16;
    localparam int REQ_BITS = 2;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Request codes
    localparam logic [REQ_BITS-1:0] REQ_PACKET = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_SAMPLE = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_READ   = 2'd2;

    // Control Change recognition
    localparam logic [3:0] CIN_CONTROL_CHANGE    = 4'hB;
    localparam logic [3:0] STATUS_CONTROL_CHANGE = 4'hB;

    // Controller numbers
    localparam logic [LEVEL_BITS-1:0] CTL_LEFT_A  = 8'd16;
    localparam logic [LEVEL_BITS-1:0] CTL_LEFT_B  = 8'd17;
    localparam logic [LEVEL_BITS-1:0] CTL_RIGHT_A = 8'd18;
    localparam logic [LEVEL_BITS-1:0] CTL_RIGHT_B = 8'd19;
    localparam logic [LEVEL_BITS-1:0] CTL_VOLUME  = 8'd7;

    // Register map (word index)
    localparam logic [0:0] REG_FALLBACK_GAP = 1'b0;
    localparam logic [GAP_BITS-1:0] GAP_RESET = 16'd100;
    localparam logic [GAP_BITS-1:0] PKT_COUNT_MAX = '1;

    // Read sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_DONE
    } t_state;

endpackage

/* src/mccm_div.sv */
`timescale 1ns / 1ps

module mccm_div import mccm_pkg::*; #(
    parameter int DEN_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SUM_BITS-1:0] i_dividend,
    input  logic [DEN_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [SUM_BITS-1:0] o_quotient
);

    logic [DEN_BITS-1:0]      r_rem, n_rem;
    logic [SUM_BITS-1:0]      r_quo, n_quo;
    logic [DEN_BITS-1:0]      r_den;
    logic [DIV_STEP_BITS-1:0] r_step;
    logic                     r_busy;
    logic                     r_done;
    logic [DEN_BITS:0]        w_rem_sh;
    logic [DEN_BITS:0]        w_diff;
    logic                     w_ge;

    // One restoring step: bring down the next dividend bit, trial subtract
    always_comb begin
        w_rem_sh = {r_rem, r_quo[SUM_BITS-1]};
        w_diff   = w_rem_sh - {1'b0, r_den};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        n_rem    = w_ge ? w_diff[DEN_BITS-1:0] : w_rem_sh[DEN_BITS-1:0];
        n_quo    = {r_quo[SUM_BITS-2:0], w_ge};
    end

    // Control: load on start, count steps, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= DIV_STEP_BITS'(SUM_BITS - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands on start, one quotient bit per cycle after
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* src/mccm_sqrt.sv */
`timescale 1ns / 1ps

module mccm_sqrt import mccm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SUM_BITS-1:0]  i_value,
    output logic                 o_done,
    output logic [ROOT_BITS-1:0] o_root
);

    logic [SUM_BITS-1:0]       r_val;
    logic [ROOT_BITS:0]        r_rem, n_rem;
    logic [ROOT_BITS-1:0]      r_root, n_root;
    logic [ROOT_STEP_BITS-1:0] r_step;
    logic                      r_busy;
    logic                      r_done;
    logic [ROOT_BITS+2:0]      w_rem_sh;
    logic [ROOT_BITS+2:0]      w_trial;
    logic [ROOT_BITS+2:0]      w_diff;
    logic                      w_ge;

    // One digit step: bring down two bits, trial subtract 4*root+1
    always_comb begin
        w_rem_sh = {r_rem, r_val[SUM_BITS-1 -: 2]};
        w_trial  = {1'b0, r_root, 2'b01};
        w_diff   = w_rem_sh - w_trial;
        w_ge     = (w_rem_sh >= w_trial);
        n_rem    = w_ge ? w_diff[ROOT_BITS:0] : w_rem_sh[ROOT_BITS:0];
        n_root   = {r_root[ROOT_BITS-2:0], w_ge};
    end

    // Control: load on start, count digit steps, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= ROOT_STEP_BITS'(ROOT_BITS - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift two radicand bits out per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[SUM_BITS-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* src/midi_cc_level_meter.sv */
`timescale 1ns / 1ps

// Level meter fed by USB MIDI Control Change packets.
// Input channel (i_in_valid / o_in_stall): one item per transfer, req_type
// selects a MIDI packet, an end-of-transfer sample, or a read-and-clear.
// Packets and sample marks produce no result; a new item can be taken on
// every cycle while only those arrive.
// A read produces one result on the output channel (o_out_valid /
// i_out_stall): held peaks and floor(sqrt(sum / count)) for both sides.
// The read is worked out on one serial divider (one quotient bit a cycle,
// 32 steps) and one serial square root (two bits a cycle, 16 steps),
// shared by left then right: divide, root, divide, root. With a zero
// sample count the roots are skipped and the sequencer goes straight to
// its done state. The input stalls for the whole read.
// The result sits in an output register; a stalled result holds, and a
// further read waits for that register to empty before it completes.
// Synchronous reset clears levels, meters, counters and the output valid,
// and loads fallback_gap with 100. fallback_gap is written over APB.
module midi_cc_level_meter import mccm_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // item input
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [REQ_BITS-1:0]      i_req_type,
    input  logic [LEVEL_BITS-1:0]    i_header_byte,
    input  logic [LEVEL_BITS-1:0]    i_status_byte,
    input  logic [LEVEL_BITS-1:0]    i_data_one,
    input  logic [LEVEL_BITS-1:0]    i_data_two,
    // result output
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [LEVEL_BITS-1:0]    o_peak_left,
    output logic [LEVEL_BITS-1:0]    o_peak_right,
    output logic [LEVEL_BITS-1:0]    o_rms_left,
    output logic [LEVEL_BITS-1:0]    o_rms_right,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_state                  r_state, n_state;
    logic [GAP_BITS-1:0]     r_gap;
    logic [LEVEL_BITS-1:0]   r_level_l, r_level_r;
    logic [GAP_BITS-1:0]     r_pkts;
    logic [LEVEL_BITS-1:0]   r_peak_l, r_peak_r;
    logic [SUM_BITS-1:0]     r_sum_l, r_sum_r;
    logic [COUNT_BITS-1:0]   r_count;
    logic                    r_lane;
    logic [LEVEL_BITS-1:0]   r_rms_l, r_rms_r;
    logic                    r_out_valid;
    logic [LEVEL_BITS-1:0]   r_out_peak_l, r_out_peak_r, r_out_rms_l, r_out_rms_r;

    logic                    w_in_acc;
    logic                    w_out_acc;
    logic                    w_cfg_wr;
    logic                    w_is_cc;
    logic                    w_count_full;
    logic [SQUARE_BITS-1:0]  w_sq_l, w_sq_r;
    logic [SUM_BITS:0]       w_add_l, w_add_r;
    logic                    w_div_start, w_div_done;
    logic [SUM_BITS-1:0]     w_quotient;
    logic                    w_sqrt_start, w_sqrt_done;
    logic [ROOT_BITS-1:0]    w_root;
    logic                    w_load;
    logic                    w_rms_zero;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign w_cfg_wr  = psel && penable && pwrite;

    // APB: single register, always ready
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FALLBACK_GAP) ?
                    {{(APB_DATA_BITS-GAP_BITS){1'b0}}, r_gap} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (w_cfg_wr && paddr[2] == REG_FALLBACK_GAP) begin
            r_gap <= pwdata[GAP_BITS-1:0];
        end
    end

    // Packet decode and sample arithmetic
    always_comb begin
        w_is_cc = (i_header_byte[3:0] == CIN_CONTROL_CHANGE) ||
                  (i_status_byte[7:4] == STATUS_CONTROL_CHANGE);
        w_count_full = &r_count;
        w_sq_l  = r_level_l * r_level_l;
        w_sq_r  = r_level_r * r_level_r;
        w_add_l = {1'b0, r_sum_l} + {{(SUM_BITS+1-SQUARE_BITS){1'b0}}, w_sq_l};
        w_add_r = {1'b0, r_sum_r} + {{(SUM_BITS+1-SQUARE_BITS){1'b0}}, w_sq_r};
    end

    // Read sequencer: divide then root, left lane then right lane
    always_comb begin
        n_state      = r_state;
        o_in_stall   = 1'b1;
        w_div_start  = 1'b0;
        w_sqrt_start = 1'b0;
        w_load       = 1'b0;
        w_rms_zero   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && i_req_type == REQ_READ) begin
                    if (r_count == '0) begin
                        w_rms_zero = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_sqrt_start = 1'b1;
                    n_state      = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_sqrt_done) begin
                    if (!r_lane) begin
                        w_div_start = 1'b1;
                        n_state     = ST_DIV;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Lane select and root capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= 1'b0;
        end else if (w_in_acc) begin
            r_lane <= 1'b0;
        end else if (w_sqrt_done) begin
            r_lane <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rms_zero) begin
            r_rms_l <= '0;
            r_rms_r <= '0;
        end else if (w_sqrt_done) begin
            if (r_lane) begin
                r_rms_r <= w_root[LEVEL_BITS-1:0];
            end else begin
                r_rms_l <= w_root[LEVEL_BITS-1:0];
            end
        end
    end

    mccm_div #(
        .DEN_BITS(COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ((w_div_start && r_state == ST_ROOT) ? r_sum_r : r_sum_l),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    mccm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_quotient),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Levels and packet gap counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_l <= '0;
            r_level_r <= '0;
            r_pkts    <= '0;
        end else if (w_in_acc && i_req_type == REQ_PACKET) begin
            if (w_is_cc) begin
                if (i_data_one == CTL_LEFT_A || i_data_one == CTL_LEFT_B) begin
                    r_level_l <= i_data_two;
                end else if (i_data_one == CTL_RIGHT_A || i_data_one == CTL_RIGHT_B) begin
                    r_level_r <= i_data_two;
                end else if (i_data_one == CTL_VOLUME && r_pkts > r_gap) begin
                    r_level_l <= i_data_two;
                    r_level_r <= i_data_two;
                end
                r_pkts <= GAP_BITS'(1);
            end else if (r_pkts != PKT_COUNT_MAX) begin
                r_pkts <= r_pkts + 1'b1;
            end
        end
    end

    // Meters: update on sample, clear when a read result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load) begin
            r_peak_l <= '0;
            r_peak_r <= '0;
            r_sum_l  <= '0;
            r_sum_r  <= '0;
            r_count  <= '0;
        end else if (w_in_acc && i_req_type == REQ_SAMPLE) begin
            if (r_level_l > r_peak_l) begin
                r_peak_l <= r_level_l;
            end
            if (r_level_r > r_peak_r) begin
                r_peak_r <= r_level_r;
            end
            if (!w_count_full) begin
                r_sum_l <= w_add_l[SUM_BITS] ? '1 : w_add_l[SUM_BITS-1:0];
                r_sum_r <= w_add_r[SUM_BITS] ? '1 : w_add_r[SUM_BITS-1:0];
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_peak_l <= r_peak_l;
            r_out_peak_r <= r_peak_r;
            r_out_rms_l  <= r_rms_l;
            r_out_rms_r  <= r_rms_r;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_peak_left  = r_out_peak_l;
    assign o_peak_right = r_out_peak_r;
    assign o_rms_left   = r_out_rms_l;
    assign o_rms_right  = r_out_rms_r;

endmodule

/* src/mccm_checker.sv */
`timescale 1ns / 1ps

module mccm_checker import mccm_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic [REQ_BITS-1:0]   i_req_type,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [LEVEL_BITS-1:0] o_peak_left,
    input logic [LEVEL_BITS-1:0] o_peak_right,
    input logic [LEVEL_BITS-1:0] o_rms_left,
    input logic [LEVEL_BITS-1:0] o_rms_right
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_peak_left) && $stable(o_peak_right) &&
            $stable(o_rms_left) && $stable(o_rms_right))
        else $error("stalled result changed");

    // Drop any result at reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A read transfer busies the input for the read sequence
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_req_type == REQ_READ |=> o_in_stall)
        else $error("input not stalled after read transfer");

    // A new result only appears at the end of a read sequence
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a read sequence");

endmodule

bind midi_cc_level_meter mccm_checker u_mccm_checker (.*);
